@@ rtl/core/time_sorted_track_buffer_predictor_assert.svh @@
// ---------------------------------------------------------------------------
// assertion macros for the track buffer predictor
// ---------------------------------------------------------------------------
`ifndef TIME_SORTED_TRACK_BUFFER_PREDICTOR_ASSERT_SVH
`define TIME_SORTED_TRACK_BUFFER_PREDICTOR_ASSERT_SVH

// implication checked at every edge outside reset
`define TSTB_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define TSTB_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ rtl/core/tstb_pkg.sv @@
// ---------------------------------------------------------------------------
// tstb_pkg
// shared types and constants of the track buffer predictor
// ---------------------------------------------------------------------------
package tstb_pkg;

    localparam int DEPTH = 5;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = 24;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FEW = 2'd1;
    localparam logic [1:0] ST_ZERO_DT = 2'd2;

    localparam logic [22:0] MARGIN_RESET = 23'd2400;

    // entry record
    typedef struct packed {
        logic [31:0]          stamp;
        logic signed [PW-1:0] pos_x;
        logic signed [PW-1:0] pos_y;
        logic signed [PW-1:0] nxt_x;
        logic signed [PW-1:0] nxt_y;
    } entry_t;

    // controller commands
    typedef struct packed {
        logic load;      // capture input word, compute clamp
        logic drop;      // shift out earliest entry
        logic shift;     // move entry up at insert pointer
        logic place;     // write new entry at insert pointer
        logic pred;      // compute predict terms, write back
        logic div_start; // start both dividers
        logic done;      // register result word
    } cmd_t;

    // datapath status
    typedef struct packed {
        logic is_pred;
        logic full;
        logic few;
        logic need_shift;
        logic div_busy;
    } stat_t;

endpackage

@@ rtl/core/tstb_ctrl.sv @@
// ---------------------------------------------------------------------------
// tstb_ctrl
// sequencer for insert and predict operations
// ---------------------------------------------------------------------------
module tstb_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             out_busy,
    input  tstb_pkg::stat_t  st,
    output tstb_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {S_IDLE, S_DEC, S_SHIFT, S_PRED, S_DIV, S_WAIT, S_DONE} state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (!st.is_pred)
                begin
                    if (st.full)
                        cmd.drop = 1'b1;
                    state_next = S_SHIFT;
                end
                else if (st.few)
                    state_next = S_DONE;
                else
                    state_next = S_PRED;
            end
            S_SHIFT:
            begin
                if (st.need_shift)
                    cmd.shift = 1'b1;
                else
                begin
                    cmd.place = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_PRED:
            begin
                cmd.pred = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!st.div_busy)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.done = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/core/tstb_div.sv @@
// ---------------------------------------------------------------------------
// tstb_div
// radix-2 restoring divider, signed 35-bit dividend by unsigned 32-bit
// divisor, quotient saturated to 32 bits
// ---------------------------------------------------------------------------
module tstb_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [34:0] num,
    input  logic [31:0]        den,
    output logic               busy,
    output logic signed [31:0] quo
);

    logic [5:0]  cnt_reg, cnt_next;
    logic [33:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [32:0] trial;
    logic [33:0] mag;
    logic signed [35:0] sq;

    assign busy = (cnt_reg != 6'd0);
    assign mag = num[34] ? 34'(-num) : num[33:0];

    // one quotient bit per cycle
    always_comb
    begin
        cnt_next = cnt_reg;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        trial = {r_reg[31:0], q_reg[33]} - {1'b0, d_reg};
        if (start)
        begin
            cnt_next = 6'd34;
            q_next = mag;
            r_next = '0;
            d_next = den;
            neg_next = num[34];
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (!trial[32])
            begin
                r_next = trial;
                q_next = {q_reg[32:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[31:0], q_reg[33]};
                q_next = {q_reg[32:0], 1'b0};
            end
        end
    end

    // signed saturation of the quotient
    always_comb
    begin
        sq = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
        if (sq > 36'sd2147483647)
            quo = 32'h7fffffff;
        else if (sq < -36'sd2147483648)
            quo = 32'h80000000;
        else
            quo = sq[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

endmodule

@@ rtl/core/tstb_datapath.sv @@
// ---------------------------------------------------------------------------
// tstb_datapath
// sorted entry registers, clamp logic, predict terms and result register
// ---------------------------------------------------------------------------
module tstb_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tstb_pkg::cmd_t       cmd,
    output tstb_pkg::stat_t      st,
    input  logic [22:0]          jump_margin,
    input  logic                 func,
    input  logic [31:0]          stamp_ms,
    input  logic signed [23:0]   pos_x,
    input  logic signed [23:0]   pos_y,
    input  logic signed [23:0]   proposed_x,
    input  logic signed [23:0]   proposed_y,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [1:0]           status,
    output logic signed [23:0]   next_x,
    output logic signed [23:0]   next_y,
    output logic signed [23:0]   disp_x,
    output logic signed [23:0]   disp_y,
    output logic signed [31:0]   vel_x,
    output logic signed [31:0]   vel_y,
    output logic [tstb_pkg::CW-1:0] fill
);

    tstb_pkg::entry_t ent_reg [tstb_pkg::DEPTH];
    tstb_pkg::entry_t new_reg;
    logic func_reg;
    logic [tstb_pkg::CW-1:0] cnt_reg;
    logic [tstb_pkg::CW-1:0] ptr_reg;
    logic [tstb_pkg::IW-1:0] last_i, prev_i, ptr_i, ptrm_i;
    logic signed [23:0] dx_reg, dy_reg;
    logic [31:0] dt_reg;
    logic        qx_busy, qy_busy;
    logic signed [31:0] qx, qy;
    tstb_pkg::entry_t lst, prv;
    logic signed [24:0] dxw, dyw, nxw, nyw;
    logic signed [23:0] dxs, dys, nxs, nys;

    assign fill = cnt_reg;
    assign last_i = tstb_pkg::IW'(cnt_reg - 1'b1);
    assign prev_i = tstb_pkg::IW'(cnt_reg - 2'd2);
    assign ptr_i = tstb_pkg::IW'(ptr_reg);
    assign ptrm_i = tstb_pkg::IW'(ptr_reg - 1'b1);
    assign lst = ent_reg[last_i];
    assign prv = ent_reg[prev_i];

    assign st.is_pred = func_reg;
    assign st.full = (cnt_reg >= tstb_pkg::CW'(tstb_pkg::DEPTH));
    assign st.few = (cnt_reg < tstb_pkg::CW'(2));
    assign st.need_shift = (ptr_reg != '0) && (ent_reg[ptrm_i].stamp > new_reg.stamp);
    assign st.div_busy = qx_busy | qy_busy;

    // clamp of one axis against latest entry
    function automatic logic signed [23:0] clamp(input logic signed [23:0] p,
        input logic signed [23:0] q, input logic signed [23:0] lp,
        input logic signed [23:0] ln, input logic [22:0] m);
        logic signed [25:0] a, b;
        logic [25:0] an, bn;
        begin
            a = 26'(q) - 26'(p);
            b = 26'(ln) - 26'(lp);
            an = a[25] ? 26'(-a) : a;
            bn = (b[25] ? 26'(-b) : b) + 26'(m);
            clamp = (an > bn) ? lp : q;
        end
    endfunction

    // saturation to 24 bits
    function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
        begin
            if (v > 25'sd8388607)
                sat24 = 24'h7fffff;
            else if (v < -25'sd8388608)
                sat24 = 24'h800000;
            else
                sat24 = v[23:0];
        end
    endfunction

    // predict terms
    always_comb
    begin
        dxw = 25'(lst.pos_x) - 25'(prv.pos_x);
        dyw = 25'(lst.pos_y) - 25'(prv.pos_y);
        dxs = sat24(dxw);
        dys = sat24(dyw);
        nxw = 25'(lst.pos_x) + 25'(dxs);
        nyw = 25'(lst.pos_y) + 25'(dys);
        nxs = sat24(nxw);
        nys = sat24(nyw);
    end

    // velocity dividers
    tstb_div u_div_x (.clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .num(35'(dx_reg) * 35'sd1000), .den(dt_reg), .busy(qx_busy), .quo(qx));
    tstb_div u_div_y (.clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .num(35'(dy_reg) * 35'sd1000), .den(dt_reg), .busy(qy_busy), .quo(qy));

    // control registers: fill count, insert pointer, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ptr_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                ptr_reg <= cnt_reg;
            if (cmd.drop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                ptr_reg <= cnt_reg - 1'b1;
            end
            if (cmd.shift)
                ptr_reg <= ptr_reg - 1'b1;
            if (cmd.place)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.done)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    // entries and work registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            new_reg.stamp <= stamp_ms;
            new_reg.pos_x <= pos_x;
            new_reg.pos_y <= pos_y;
            if (!st.few)
            begin
                new_reg.nxt_x <= clamp(pos_x, proposed_x, lst.pos_x, lst.nxt_x, jump_margin);
                new_reg.nxt_y <= clamp(pos_y, proposed_y, lst.pos_y, lst.nxt_y, jump_margin);
            end
            else
            begin
                new_reg.nxt_x <= proposed_x;
                new_reg.nxt_y <= proposed_y;
            end
        end
        if (cmd.drop)
        begin
            for (int k = 0; k + 1 < tstb_pkg::DEPTH; k++)
                ent_reg[k] <= ent_reg[k + 1];
        end
        if (cmd.shift)
            ent_reg[ptr_i] <= ent_reg[ptrm_i];
        if (cmd.place)
            ent_reg[ptr_i] <= new_reg;
        if (cmd.pred)
        begin
            ent_reg[last_i].nxt_x <= nxs;
            ent_reg[last_i].nxt_y <= nys;
            dx_reg <= dxs;
            dy_reg <= dys;
            dt_reg <= lst.stamp - prv.stamp;
            new_reg.nxt_x <= nxs;
            new_reg.nxt_y <= nys;
        end
        if (cmd.done)
        begin
            if (!func_reg)
            begin
                status <= tstb_pkg::ST_OK;
                next_x <= new_reg.nxt_x;
                next_y <= new_reg.nxt_y;
                disp_x <= '0;
                disp_y <= '0;
                vel_x <= '0;
                vel_y <= '0;
            end
            else if (st.few)
            begin
                status <= tstb_pkg::ST_FEW;
                next_x <= '0;
                next_y <= '0;
                disp_x <= '0;
                disp_y <= '0;
                vel_x <= '0;
                vel_y <= '0;
            end
            else
            begin
                next_x <= new_reg.nxt_x;
                next_y <= new_reg.nxt_y;
                disp_x <= dx_reg;
                disp_y <= dy_reg;
                if (dt_reg == '0)
                begin
                    status <= tstb_pkg::ST_ZERO_DT;
                    vel_x <= '0;
                    vel_y <= '0;
                end
                else
                begin
                    status <= tstb_pkg::ST_OK;
                    vel_x <= qx;
                    vel_y <= qy;
                end
            end
        end
    end

endmodule

@@ rtl/core/time_sorted_track_buffer_predictor.sv @@
// ---------------------------------------------------------------------------
// time_sorted_track_buffer_predictor
// time-ordered position buffer with jump clamp and dead-reckoning predict
// ---------------------------------------------------------------------------
// channel  direction  handshake                 words
// in       input      in_valid / in_ready       func, stamp, positions
// out      output     out_valid / out_ready     status, next, disp, vel
// cfg      input      cfg_valid / cfg_ready     jump_margin
//
// insert: load, decode, a shift step per entry moved by the sorted shift, then place
// predict: terms, then the 34-step serial velocity divider; skipped with few entries
// one word in flight; a stalled result holds the next word in its last step
// reset empties the buffer and restores jump_margin to 2400
// ---------------------------------------------------------------------------
`include "time_sorted_track_buffer_predictor_assert.svh"

module time_sorted_track_buffer_predictor
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [31:0]        stamp_ms,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [23:0] proposed_x,
    input  logic signed [23:0] proposed_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [23:0] next_x,
    output logic signed [23:0] next_y,
    output logic signed [23:0] disp_x,
    output logic signed [23:0] disp_y,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [22:0]        cfg_data
);

    tstb_pkg::cmd_t  cmd;
    tstb_pkg::stat_t st;
    logic [22:0] margin_reg;
    logic [tstb_pkg::CW-1:0] fill;
    logic [4:0] cmd_bits;

    assign cfg_ready = 1'b1;
    assign cmd_bits = {cmd.load, cmd.shift, cmd.place, cmd.pred, cmd.done};

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            margin_reg <= tstb_pkg::MARGIN_RESET;
        else if (cfg_valid)
            margin_reg <= cfg_data;
    end

    tstb_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_valid(in_valid),
        .in_ready(in_ready), .out_busy(out_valid && !out_ready), .st(st), .cmd(cmd));

    tstb_datapath u_dp (.clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
        .jump_margin(margin_reg), .func(func), .stamp_ms(stamp_ms),
        .pos_x(pos_x), .pos_y(pos_y), .proposed_x(proposed_x),
        .proposed_y(proposed_y), .out_ready(out_ready), .out_valid(out_valid),
        .status(status), .next_x(next_x), .next_y(next_y), .disp_x(disp_x),
        .disp_y(disp_y), .vel_x(vel_x), .vel_y(vel_y), .fill(fill));

    // checks
    `TSTB_ASSERT_IMP(a_fill_max, clk, rst_n, 1'b1, fill <= tstb_pkg::CW'(tstb_pkg::DEPTH))
    `TSTB_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd_bits))
    `TSTB_ASSERT_NEXT(a_done_valid, clk, rst_n, cmd.done, out_valid)
    `TSTB_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, status <= tstb_pkg::ST_ZERO_DT)

endmodule

@@ bench/tb_time_sorted_track_buffer_predictor.sv @@
// ---------------------------------------------------------------------------
// tb_time_sorted_track_buffer_predictor
// self-checking bench: random and directed insert/predict words with random
// gaps and stalls on both sides, results compared against an internal model
// ---------------------------------------------------------------------------
module tb_time_sorted_track_buffer_predictor;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FN_INSERT  = 1'b0;
    localparam logic FN_PREDICT = 1'b1;
    localparam longint PMAX = 64'sd8388607;
    localparam longint PMIN = -64'sd8388608;

    typedef struct packed {
        logic        func;
        logic [31:0] stamp;
        logic [23:0] px;
        logic [23:0] py;
        logic [23:0] qx;
        logic [23:0] qy;
    } word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] nx;
        logic [23:0] ny;
        logic [23:0] dx;
        logic [23:0] dy;
        logic [31:0] vx;
        logic [31:0] vy;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic func = 1'b0;
    logic [31:0] stamp_ms = '0;
    logic signed [23:0] pos_x = '0, pos_y = '0, proposed_x = '0, proposed_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] status;
    logic signed [23:0] next_x, next_y, disp_x, disp_y;
    logic signed [31:0] vel_x, vel_y;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [22:0] cfg_data = '0;

    word_t   pending_words[$];
    result_t expected_results[$];
    int      error_count = 0;
    bit      hold_sender = 1'b0;
    int      in_gap = 0;
    int      out_gap = 0;

    // track model state
    logic [31:0] trk_stamp[tstb_pkg::DEPTH];
    longint      trk_px[tstb_pkg::DEPTH], trk_py[tstb_pkg::DEPTH];
    longint      trk_nx[tstb_pkg::DEPTH], trk_ny[tstb_pkg::DEPTH];
    int          trk_fill = 0;
    longint      margin = 2400;

    always #5 clk = ~clk;

    time_sorted_track_buffer_predictor u_dut (.*);

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clamp_jump(longint p, longint q, longint lp, longint ln);
        return (mag(q - p) > mag(ln - lp) + margin) ? lp : q;
    endfunction

    // advance the track model by one word, return its result
    function automatic result_t track_step(word_t w);
        result_t r;
        longint px, py, nx, ny, dx, dy;
        logic [31:0] dt;
        int k, a, b;
        r = '0;
        if (w.func == FN_INSERT) begin
            px = longint'($signed(w.px));
            py = longint'($signed(w.py));
            nx = longint'($signed(w.qx));
            ny = longint'($signed(w.qy));
            if (trk_fill >= 2) begin
                nx = clamp_jump(px, nx, trk_px[trk_fill-1], trk_nx[trk_fill-1]);
                ny = clamp_jump(py, ny, trk_py[trk_fill-1], trk_ny[trk_fill-1]);
            end
            if (trk_fill >= tstb_pkg::DEPTH) begin
                for (k = 0; k < tstb_pkg::DEPTH - 1; k++) begin
                    trk_stamp[k] = trk_stamp[k+1];
                    trk_px[k] = trk_px[k+1];
                    trk_py[k] = trk_py[k+1];
                    trk_nx[k] = trk_nx[k+1];
                    trk_ny[k] = trk_ny[k+1];
                end
                trk_fill = tstb_pkg::DEPTH - 1;
            end
            k = trk_fill;
            while (k > 0 && trk_stamp[k-1] > w.stamp) begin
                trk_stamp[k] = trk_stamp[k-1];
                trk_px[k] = trk_px[k-1];
                trk_py[k] = trk_py[k-1];
                trk_nx[k] = trk_nx[k-1];
                trk_ny[k] = trk_ny[k-1];
                k--;
            end
            trk_stamp[k] = w.stamp;
            trk_px[k] = px;
            trk_py[k] = py;
            trk_nx[k] = nx;
            trk_ny[k] = ny;
            trk_fill++;
            r.status = tstb_pkg::ST_OK;
            r.nx = nx[23:0];
            r.ny = ny[23:0];
        end else if (trk_fill < 2) begin
            r.status = tstb_pkg::ST_FEW;
        end else begin
            a = trk_fill - 1;
            b = trk_fill - 2;
            dt = trk_stamp[a] - trk_stamp[b];
            dx = sat(trk_px[a] - trk_px[b], PMIN, PMAX);
            dy = sat(trk_py[a] - trk_py[b], PMIN, PMAX);
            nx = sat(trk_px[a] + dx, PMIN, PMAX);
            ny = sat(trk_py[a] + dy, PMIN, PMAX);
            trk_nx[a] = nx;
            trk_ny[a] = ny;
            r.nx = nx[23:0];
            r.ny = ny[23:0];
            r.dx = dx[23:0];
            r.dy = dy[23:0];
            if (dt == 0) begin
                r.status = tstb_pkg::ST_ZERO_DT;
            end else begin
                r.status = tstb_pkg::ST_OK;
                r.vx = 32'(sat((dx * 1000) / longint'(dt), -64'sd2147483648,
                               64'sd2147483647));
                r.vy = 32'(sat((dy * 1000) / longint'(dt), -64'sd2147483648,
                               64'sd2147483647));
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver: input words from the pending queue
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                expected_results = {expected_results, track_step(
                    {func, stamp_ms, pos_x, pos_y, proposed_x, proposed_y})};
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_words.size() > 0 &&
                             !(hold_sender && expected_results.size() > 0)) begin
                    word_t w;
                    w = pending_words.pop_front();
                    in_valid <= 1'b1;
                    func <= w.func;
                    stamp_ms <= w.stamp;
                    pos_x <= w.px;
                    pos_y <= w.py;
                    proposed_x <= w.qx;
                    proposed_y <= w.qy;
                    in_gap <= pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: result words and stall pattern on the output
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", status, 0);
                end else begin
                    result_t e;
                    e = expected_results.pop_front();
                    if (status !== e.status) report_mismatch("status", status, e.status);
                    if (next_x !== e.nx) report_mismatch("next_x", next_x, e.nx);
                    if (next_y !== e.ny) report_mismatch("next_y", next_y, e.ny);
                    if (disp_x !== e.dx) report_mismatch("disp_x", disp_x, e.dx);
                    if (disp_y !== e.dy) report_mismatch("disp_y", disp_y, e.dy);
                    if (vel_x !== e.vx) report_mismatch("vel_x", vel_x, e.vx);
                    if (vel_y !== e.vy) report_mismatch("vel_y", vel_y, e.vy);
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
            end
        end
    end

    function automatic logic [23:0] rand_pos(int mode);
        case (mode)
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom);
            default: return 24'($signed($urandom_range(0, 800)) - 400);
        endcase
    endfunction

    task automatic add_word(logic f, logic [31:0] s, logic [23:0] px, logic [23:0] py,
                            logic [23:0] qx, logic [23:0] qy);
        word_t w;
        w.func = f;
        w.stamp = s;
        w.px = px;
        w.py = py;
        w.qx = qx;
        w.qy = qy;
        pending_words = {pending_words, w};
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_margin(logic [22:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        margin = longint'(v);
    endtask

    task automatic random_phase(int n);
        logic [31:0] base;
        int i, m;
        base = $urandom;
        for (i = 0; i < n; i++) begin
            m = $urandom_range(0, 9);
            if (m < 6) begin
                // mostly increasing times with jitter, some equal or late
                base = base + $urandom_range(0, 60);
                add_word(FN_INSERT,
                         ($urandom_range(0, 5) == 0) ? base - $urandom_range(0, 100) : base,
                         rand_pos($urandom_range(0, 9) < 8 ? 3 : $urandom_range(0, 2)),
                         rand_pos($urandom_range(0, 9) < 8 ? 3 : $urandom_range(0, 2)),
                         rand_pos($urandom_range(0, 9) < 7 ? 3 : $urandom_range(0, 2)),
                         rand_pos($urandom_range(0, 9) < 7 ? 3 : $urandom_range(0, 2)));
            end else if (m < 9) begin
                add_word(FN_PREDICT, $urandom, 24'($urandom), 24'($urandom),
                         24'($urandom), 24'($urandom));
            end else begin
                add_word(1'($urandom), $urandom, rand_pos(2), rand_pos(2),
                         rand_pos(2), rand_pos(2));
            end
        end
    endtask

    // stimulus
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty and single-entry predict, extremes, equal times,
        // zero interval, overflow, full-buffer drop, clamp both ways
        add_word(FN_PREDICT, 0, 0, 0, 0, 0);
        add_word(FN_INSERT, 32'd100, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
        add_word(FN_PREDICT, 0, 0, 0, 0, 0);
        add_word(FN_INSERT, 32'd100, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
        add_word(FN_PREDICT, 0, 0, 0, 0, 0);
        add_word(FN_INSERT, 32'd1, 24'd16, 24'd32, 24'd5000, 24'd40);
        add_word(FN_INSERT, 32'hFFFFFFFF, 24'd100, 24'hFFFF00, 24'd120, 24'hFFFF00);
        add_word(FN_PREDICT, 0, 0, 0, 0, 0);
        add_word(FN_INSERT, 32'hFFFFFFFF, 24'd0, 24'd0, 24'd0, 24'd0);
        add_word(FN_INSERT, 32'd50, 24'd10, 24'd10, 24'd20, 24'd20);
        add_word(FN_INSERT, 32'hFFFFFFFE, 24'h400000, 24'hC00000, 24'h7FFFFF, 24'h800000);
        add_word(FN_PREDICT, 0, 0, 0, 0, 0);
        add_word(FN_INSERT, 32'h0, 24'd1, 24'd1, 24'd1, 24'd1);
        add_word(FN_PREDICT, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        drain();

        // margin extremes with random traffic between
        write_margin(23'd0);
        random_phase(90);
        // let the sender stall until everything is back
        hold_sender = 1'b1;
        drain();
        hold_sender = 1'b0;
        write_margin(23'h7FFFFF);
        random_phase(90);
        drain();
        write_margin(23'd1);
        random_phase(110);
        drain();
        write_margin(23'($urandom));
        random_phase(110);
        drain();

        if (error_count == 0) begin
            $display("PASS time_sorted_track_buffer_predictor");
        end else begin
            $display("FAIL time_sorted_track_buffer_predictor");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("FAIL time_sorted_track_buffer_predictor");
        $finish;
    end
endmodule
